/* sv/fvn_pkg.sv */
`timescale 1ns / 1ps

package fvn_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_BITS   = 16;

  // Q5.F output word
  localparam int OUT_W  = FRAC_BITS + 5;
  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int FREQ_W = 16 + MAX_OCTAVES - 1;
  // corner values are Q2.F signed
  localparam int CV_W   = FRAC_BITS + 2;
  localparam int AMP_W  = FRAC_BITS + 1;
  localparam int SUM_W  = FRAC_BITS + $clog2(MAX_OCTAVES) + 5;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int IN_W   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 4'd3;

  localparam logic [3:0]  RST_OCTAVES   = 4'd6;
  localparam logic [15:0] RST_PERSIST   = 16'd32768;
  localparam logic [15:0] RST_INV_SCALE = 16'd3277;
  localparam logic [31:0] RST_SEED      = 32'd0;

  localparam logic [31:0] HASH_SQ_MUL = 32'd15731;
  localparam logic [31:0] HASH_ADD_A  = 32'd789221;
  localparam logic [31:0] HASH_ADD_B  = 32'd1376312589;

  typedef struct packed {
    logic [3:0]  octave_count;
    logic [15:0] persistence;
    logic [15:0] inv_scale;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage

/* sv/fractal_value_noise.sv */
`timescale 1ns / 1ps

// channel  | dir | handshake                   | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata: x_coord, y_coord
// m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: noise_value
// cfg      | in  | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// a sample runs N octaves, N = octave count clamped to 1..8, and goes straight to done for N = 0;
// each octave issues 19 products on the single shared 33x33 multiplier:
// two coordinate products, three per corner hash, three lerps, weight and decay
// rst is synchronous; config registers return to 6, 32768, 3277 and 0
// s_axis_tready is high only when the sequencer is idle; one output word register
// lets the next sample start while m_axis holds a stalled word
module fractal_value_noise (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fvn_pkg::IN_W-1:0]          s_axis_tdata,   // x_coord, y_coord
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fvn_pkg::OUT_TW-1:0]        m_axis_tdata,   // noise_value, zero pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fvn_pkg::*;

  cfg_t                     cfg;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  logic                     core_idle, core_done, out_load;
  logic [OUT_W-1:0]         core_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.octave_count <= RST_OCTAVES;
      cfg.persistence  <= RST_PERSIST;
      cfg.inv_scale    <= RST_INV_SCALE;
      cfg.seed         <= RST_SEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OCTAVES:   cfg.octave_count <= cfg_data[3:0];
        REG_PERSIST:   cfg.persistence  <= cfg_data[15:0];
        REG_INV_SCALE: cfg.inv_scale    <= cfg_data[15:0];
        REG_SEED:      cfg.seed         <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  fvn_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  fvn_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .start   (s_axis_tvalid),
    .in_x    (s_axis_tdata[COORD_BITS-1:0]),
    .in_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .idle    (core_idle),
    .done    (core_done),
    .result  (core_result),
    .take    (out_load),
    .mul_req (mul_req),
    .prod    (prod)
  );

  assign s_axis_tready = core_idle;

  // result moves into the output word register once that slot is free
  assign out_load = core_done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_TW'(core_result);
    end
  end

endmodule

/* sv/fvn_mul.sv */
`timescale 1ns / 1ps

module fvn_mul (
  input  logic                              clk,
  input  fvn_pkg::mul_req_t                 req,
  output logic signed [fvn_pkg::PROD_W-1:0] prod
);
  import fvn_pkg::*;

  // registered signed product, hash steps use only the low word
  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end

endmodule

/* sv/fvn_core.sv */
`timescale 1ns / 1ps

module fvn_core (
  input  logic                              clk,
  input  logic                              rst,
  input  fvn_pkg::cfg_t                     cfg,
  input  logic                              start,
  input  logic [fvn_pkg::COORD_BITS-1:0]    in_x,
  input  logic [fvn_pkg::COORD_BITS-1:0]    in_y,
  output logic                              idle,
  output logic                              done,
  output logic [fvn_pkg::OUT_W-1:0]         result,
  input  logic                              take,
  output fvn_pkg::mul_req_t                 mul_req,
  input  logic signed [fvn_pkg::PROD_W-1:0] prod
);
  import fvn_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_OCT  = 20'h00002,
    ST_CAPX = 20'h00004,
    ST_CAPY = 20'h00008,
    ST_HN   = 20'h00010,
    ST_HSQ  = 20'h00020,
    ST_HK   = 20'h00040,
    ST_HADD = 20'h00080,
    ST_HT   = 20'h00100,
    ST_HEND = 20'h00200,
    ST_HST  = 20'h00400,
    ST_L1   = 20'h00800,
    ST_L2   = 20'h01000,
    ST_L3   = 20'h02000,
    ST_L4   = 20'h04000,
    ST_L5   = 20'h08000,
    ST_L6   = 20'h10000,
    ST_L7   = 20'h20000,
    ST_AMP  = 20'h40000,
    ST_DONE = 20'h80000
  } state_t;

  localparam logic signed [SUM_W-1:0] SUM_LIMIT = SUM_W'(8) << FRAC_BITS;
  localparam logic [CV_W-1:0]         CV_ONE    = CV_W'(1) << FRAC_BITS;
  localparam logic [AMP_W-1:0]        AMP_ONE   = AMP_W'(1) << FRAC_BITS;

  state_t state;

  logic [COORD_BITS-1:0] x, y;
  logic [OCT_W-1:0]      oct, count;
  logic [31:0]           ix, iy, s131, n, tmp;
  logic [FRAC_BITS-1:0]  fx, fy;
  logic [1:0]            corner;
  logic [CV_W-1:0]       cv [4];
  logic [CV_W-1:0]       r1, r2;
  logic [AMP_W-1:0]      amp;
  logic signed [SUM_W-1:0] sum, sat;

  logic [FREQ_W-1:0] freq;
  logic [31:0]       sd, xi, yi, n0;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [CV_W:0]     step;
  logic signed [CV_W:0]     d_ab, d_cd, d_r;

  assign freq    = FREQ_W'(cfg.inv_scale) << oct;
  assign sd      = cfg.seed + 32'(oct);
  assign xi      = ix + 32'(corner[0]);
  assign yi      = iy + 32'(corner[1]);
  // lattice mix: x + y*57 + seed*131, seed part taken once per octave
  assign n0      = xi + (yi << 6) - (yi << 3) + yi + s131;
  assign prod_sh = prod >>> FRAC_BITS;
  assign step    = prod_sh[CV_W:0];
  assign d_ab    = {cv[1][CV_W-1], cv[1]} - {cv[0][CV_W-1], cv[0]};
  assign d_cd    = {cv[3][CV_W-1], cv[3]} - {cv[2][CV_W-1], cv[2]};
  assign d_r     = {r2[CV_W-1], r2} - {r1[CV_W-1], r1};

  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state)
      ST_OCT: begin
        mul_req.a = $signed(MUL_W'(x));
        mul_req.b = $signed(MUL_W'(freq));
      end
      ST_CAPX: begin
        mul_req.a = $signed(MUL_W'(y));
        mul_req.b = $signed(MUL_W'(freq));
      end
      ST_HSQ: begin
        mul_req.a = $signed(MUL_W'(n));
        mul_req.b = $signed(MUL_W'(n));
      end
      ST_HK: begin
        mul_req.a = $signed(MUL_W'(prod[31:0]));
        mul_req.b = $signed(MUL_W'(HASH_SQ_MUL));
      end
      ST_HT: begin
        mul_req.a = $signed(MUL_W'(n));
        mul_req.b = $signed(MUL_W'(tmp));
      end
      ST_L1: begin
        mul_req.a = MUL_W'(d_ab);
        mul_req.b = $signed(MUL_W'(fx));
      end
      ST_L2: begin
        mul_req.a = MUL_W'(d_cd);
        mul_req.b = $signed(MUL_W'(fx));
      end
      ST_L4: begin
        mul_req.a = MUL_W'(d_r);
        mul_req.b = $signed(MUL_W'(fy));
      end
      ST_L6: begin
        mul_req.a = MUL_W'($signed(r1));
        mul_req.b = $signed(MUL_W'(amp));
      end
      ST_L7: begin
        mul_req.a = $signed(MUL_W'(amp));
        mul_req.b = $signed(MUL_W'(cfg.persistence));
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  always_comb begin
    if (sum > SUM_LIMIT) begin
      sat = SUM_LIMIT;
    end else if (sum < -SUM_LIMIT) begin
      sat = -SUM_LIMIT;
    end else begin
      sat = sum;
    end
  end

  assign result = OUT_W'(sat);
  assign idle   = (state == ST_IDLE);
  assign done   = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      oct    <= '0;
      count  <= '0;
      corner <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            x      <= in_x;
            y      <= in_y;
            oct    <= '0;
            corner <= '0;
            amp    <= AMP_ONE;
            sum    <= '0;
            if (cfg.octave_count > MAX_OCTAVES) begin
              count <= OCT_W'(MAX_OCTAVES);
            end else begin
              count <= OCT_W'(cfg.octave_count);
            end
            state <= (cfg.octave_count == 4'd0) ? ST_DONE : ST_OCT;
          end
        end
        ST_OCT: begin
          s131  <= (sd << 7) + (sd << 1) + sd;
          state <= ST_CAPX;
        end
        ST_CAPX: begin
          ix    <= prod[FRAC_BITS +: 32];
          fx    <= prod[FRAC_BITS-1:0];
          state <= ST_CAPY;
        end
        ST_CAPY: begin
          iy    <= prod[FRAC_BITS +: 32];
          fy    <= prod[FRAC_BITS-1:0];
          state <= ST_HN;
        end
        ST_HN: begin
          n     <= (n0 << 13) ^ n0;
          state <= ST_HSQ;
        end
        ST_HSQ: begin
          state <= ST_HK;
        end
        ST_HK: begin
          state <= ST_HADD;
        end
        ST_HADD: begin
          tmp   <= prod[31:0] + HASH_ADD_A;
          state <= ST_HT;
        end
        ST_HT: begin
          state <= ST_HEND;
        end
        ST_HEND: begin
          tmp   <= (prod[31:0] + HASH_ADD_B) & 32'h7fff_ffff;
          state <= ST_HST;
        end
        ST_HST: begin
          // 1 - hash / 2^30 in Q2.F
          cv[corner] <= CV_ONE - CV_W'(tmp[30 -: FRAC_BITS + 1]);
          corner     <= corner + 1'b1;
          state      <= (corner == 2'd3) ? ST_L1 : ST_HN;
        end
        ST_L1: begin
          state <= ST_L2;
        end
        ST_L2: begin
          r1    <= CV_W'({cv[0][CV_W-1], cv[0]} + step);
          state <= ST_L3;
        end
        ST_L3: begin
          r2    <= CV_W'({cv[2][CV_W-1], cv[2]} + step);
          state <= ST_L4;
        end
        ST_L4: begin
          state <= ST_L5;
        end
        ST_L5: begin
          r1    <= CV_W'({r1[CV_W-1], r1} + step);
          state <= ST_L6;
        end
        ST_L6: begin
          state <= ST_L7;
        end
        ST_L7: begin
          sum   <= sum + SUM_W'(prod_sh);
          state <= ST_AMP;
        end
        ST_AMP: begin
          amp   <= prod[16 +: AMP_W];
          oct   <= oct + 1'b1;
          state <= (OCT_W'(oct + 1'b1) == count) ? ST_DONE : ST_OCT;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_oct_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_DONE) |-> (oct < count))
    else $error("octave index past octave count");

  a_amp_decays: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AMP) |=> (amp <= $past(amp)))
    else $error("amplitude grew");

  a_start_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (sum == '0 && corner == 2'd0))
    else $error("accumulator not cleared on start");

  a_corners_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_L1) |-> (corner == 2'd0))
    else $error("corner counter out of step");
`endif

endmodule

/* test/fractal_value_noise_chk.sv */
`timescale 1ns / 1ps

module fractal_value_noise_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [fvn_pkg::IN_W-1:0]       s_axis_tdata,   // x_coord, y_coord
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [fvn_pkg::OUT_TW-1:0]     m_axis_tdata,   // noise_value, zero pad
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding,
  output int                             checked_count
);
  import fvn_pkg::*;

  localparam logic [31:0] HASH_ROW_MUL  = 32'd57;
  localparam logic [31:0] HASH_SEED_MUL = 32'd131;
  localparam int          HASH_SHIFT    = 13;
  localparam int          REPORT_MAX    = 10;

  cfg_t              shadow;
  logic [OUT_TW-1:0] noise_q[$];
  logic [OUT_TW-1:0] want;

  // corner height of one lattice point, signed Q2.16
  function automatic longint lattice_level(logic [31:0] xi, logic [31:0] yi,
                                           logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] t;
    h = xi + yi * HASH_ROW_MUL + seed * HASH_SEED_MUL;
    h = (h << HASH_SHIFT) ^ h;
    t = h * (h * h * HASH_SQ_MUL + HASH_ADD_A) + HASH_ADD_B;
    t = t & 32'h7fff_ffff;
    return (longint'(1) << FRAC_BITS) - longint'(t >> (30 - FRAC_BITS));
  endfunction

  // floor(v * f / 2^F), rounding toward minus infinity
  function automatic longint q_scale(longint v, longint f);
    return (v * f) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(longint lo, longint hi, longint f);
    return lo + q_scale(hi - lo, f);
  endfunction

  function automatic logic [OUT_TW-1:0] predict_noise(logic [COORD_BITS-1:0] x,
                                                      logic [COORD_BITS-1:0] y);
    int          octaves;
    int          i;
    longint      amp, total, limit, px, py, fx, fy, freq;
    longint      a, b, c, d, row0, row1, level;
    logic [31:0] ix, iy, seed;
    logic [OUT_W-1:0] word;
    octaves = int'(shadow.octave_count);
    if (octaves > MAX_OCTAVES) octaves = MAX_OCTAVES;
    amp   = longint'(1) << FRAC_BITS;
    total = 0;
    limit = longint'(8) << FRAC_BITS;
    for (i = 0; i < octaves; i++) begin
      freq = longint'(shadow.inv_scale) << i;
      px   = longint'(x) * freq;
      py   = longint'(y) * freq;
      ix   = 32'(px >>> FRAC_BITS);
      iy   = 32'(py >>> FRAC_BITS);
      fx   = px & ((longint'(1) << FRAC_BITS) - 1);
      fy   = py & ((longint'(1) << FRAC_BITS) - 1);
      seed = shadow.seed + 32'(i);
      a    = lattice_level(ix, iy, seed);
      b    = lattice_level(ix + 32'd1, iy, seed);
      c    = lattice_level(ix, iy + 32'd1, seed);
      d    = lattice_level(ix + 32'd1, iy + 32'd1, seed);
      row0 = blend(a, b, fx);
      row1 = blend(c, d, fx);
      level = blend(row0, row1, fy);
      total += q_scale(level, amp);
      amp = (amp * longint'(shadow.persistence)) >> 16;
    end
    if (total > limit) total = limit;
    if (total < -limit) total = -limit;
    word = OUT_W'(total);
    return OUT_TW'(word);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shadow        <= '{RST_OCTAVES, RST_PERSIST, RST_INV_SCALE, RST_SEED};
      noise_q.delete();
      outstanding   <= 0;
      fail_count    <= 0;
      checked_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OCTAVES:   shadow.octave_count <= cfg_data[3:0];
          REG_PERSIST:   shadow.persistence  <= cfg_data[15:0];
          REG_INV_SCALE: shadow.inv_scale    <= cfg_data[15:0];
          REG_SEED:      shadow.seed         <= cfg_data;
          default: ;
        endcase
      end
      // retire before predicting so a word can never match its own sample's edge
      if (m_axis_tvalid && m_axis_tready) begin
        checked_count <= checked_count + 1;
        if (noise_q.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("[%0t] unexpected word: noise_value %0d (tdata %h)", $time,
                     $signed(m_axis_tdata[OUT_W-1:0]), m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = noise_q.pop_front();
          if (m_axis_tdata !== want) begin
            if (fail_count < REPORT_MAX)
              $display("[%0t] noise_value mismatch: expected %0d (tdata %h) got %0d (tdata %h)",
                       $time, $signed(want[OUT_W-1:0]), want,
                       $signed(m_axis_tdata[OUT_W-1:0]), m_axis_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        noise_q.push_back(predict_noise(s_axis_tdata[COORD_BITS-1:0],
                                        s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
      outstanding <= outstanding + int'(s_axis_tvalid && s_axis_tready)
                                 - int'(m_axis_tvalid && m_axis_tready);
    end
  end

endmodule

/* test/fractal_value_noise_tb.sv */
`timescale 1ns / 1ps

module fractal_value_noise_tb;
  import fvn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
  localparam int RESET_CYCLES = 12;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 97;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 12000;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;   // x_coord, y_coord
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TW-1:0]     m_axis_tdata;         // noise_value, zero pad
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int fail_count, outstanding, checked_count;
  int src_idle_pct    = 28;
  int sink_idle_pct   = 48;
  int holds_requested = 0;
  int holds_served    = 0;
  int quiet_cycles    = 0;
  int samples_sent    = 0;
  int cfg_writes      = 0;

  fractal_value_noise DUT (.*);

  fractal_value_noise_chk noise_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (holds_requested != holds_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_served++;
      end else begin
        m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stalled: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, outstanding);
      $display("fractal_value_noise verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({y, x});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
  endtask

  // stop offering and let every predicted word come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  // unused upper data bits carry junk, the block must drop them
  task automatic load_settings(input logic [3:0] octaves, input logic [15:0] persist,
                               input logic [15:0] inv_scale, input logic [31:0] seed,
                               input bit stray);
    drain();
    write_reg(REG_OCTAVES, {28'($urandom), octaves});
    write_reg(REG_PERSIST, {16'($urandom), persist});
    write_reg(REG_INV_SCALE, {16'($urandom), inv_scale});
    write_reg(REG_SEED, seed);
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_SEED) + 1, (1 << CFG_IDX_W) - 1)),
                $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int          p;
    int          k;
    logic [3:0]  octaves;
    logic [15:0] inv_scale;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    push_sample(0, 0);
    push_sample(4095, 4095);
    push_sample(4095, 0);
    push_sample(0, 4095);
    // no octaves at all
    load_settings(4'd0, 16'd32768, 16'd3277, 32'd0, 1'b0);
    push_sample(1234, 567);
    push_sample(4095, 4095);
    // octave count past the maximum, full persistence and scale, seed wraps
    load_settings(4'd15, 16'hffff, 16'hffff, 32'h7fff_ffff, 1'b0);
    write_reg(REG_UNUSED, 32'hffff_ffff);
    cfg_valid <= 1'b0;
    @(posedge clk);
    push_sample(4095, 4095);
    push_sample(0, 0);
    push_sample(2048, 1);
    push_sample(4095, 1);
    // zero frequency and zero persistence
    load_settings(4'd8, 16'd0, 16'd0, 32'h8000_0000, 1'b0);
    push_sample(0, 0);
    push_sample(4095, 4095);
    push_sample(777, 3000);
    // single octave at the smallest scale
    load_settings(4'd1, 16'hffff, 16'd1, 32'hffff_ffff, 1'b0);
    push_sample(4095, 4095);
    push_sample(1, 4095);
    load_settings(4'd9, 16'd12345, 16'd40000, 32'h1234_5678, 1'b0);
    push_sample(100, 200);
    push_sample(4000, 31);

    for (p = 0; p < PHASES; p++) begin
      octaves   = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                           : 4'($urandom_range(1, MAX_OCTAVES));
      inv_scale = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
      load_settings(octaves, 16'($urandom), inv_scale, $urandom, $urandom_range(2) == 0);
      if (p == 2) begin
        src_idle_pct  = 48;
        sink_idle_pct <= 28;
      end else if (p == PHASES - 1) begin
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 20) holds_requested <= holds_requested + 1;
        if (p == 3 && k == PHASE_ITEMS / 2) drain();
        push_sample(pick_coord(), pick_coord());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d samples over %0d register writes, %0d words compared",
             samples_sent, cfg_writes, checked_count);
    $display("octave counts 0..15, zero scale and decay, %0d-cycle output hold, three idle mixes",
             HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("fractal_value_noise verification clean");
    end else begin
      $display("fractal_value_noise verification failed");
    end
    $finish;
  end

endmodule
